### hw/rtl/ffra_pkg.sv
// shared types, constants and status codes of the first-fit range allocator
package ffra_pkg;

    localparam int unsigned MAX_OWNERS_DEF   = 64;
    localparam int unsigned MAX_SEGMENTS_DEF = 65;
    localparam int unsigned ADDR_BITS_DEF    = 32;

    localparam int unsigned CAP_W   = 33;
    localparam int unsigned OWNER_W = 6;
    localparam int unsigned OUT_W   = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 33'd65536;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_BUSY      = 3'd3,
        ST_ZERO_SIZE = 3'd4
    } t_status;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_AREAD,
        S_ACHK,
        S_OREAD,
        S_FREAD,
        S_FCHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

endpackage

### hw/rtl/ffra_ram.sv
// generic single-port-write, single-read ram with registered read data
module ffra_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/first_fit_range_allocator.sv
// top level of the first-fit range allocator with coalescing free list
//
// Usage: an item (cmd, owner id, size) enters on the input channel when
// i_valid is high and o_stall low. Allocate grants the low part of the
// lowest-address free segment that can hold the size; free returns the
// owner's range and merges it with neighbouring segments. Each item gives
// exactly one result item (status, range_start, range_end) on the output
// channel, held while i_stall is high.
// Timing: one item at a time. Free segments are visited in turn through the
// segment ram's one read port, each read and then checked; dropping or
// inserting a segment shifts the tail of the list one entry at a time, each
// entry read and then written back.
// A new item is accepted while a finished result still waits in the output
// register; a stalled receiver holds the next item in the done state.
// Writing capacity (i_cfg_valid with o_cfg_ready) rebuilds the list as one
// segment, or none for 0, and releases every owner; it is taken while idle
// with no result waiting. Reset (i_rst_n low, synchronous) restores capacity
// 65536, one free segment and no owners; no clearing pass is needed.
module first_fit_range_allocator
    import ffra_pkg::*;
#(
    parameter int unsigned MAX_OWNERS   = MAX_OWNERS_DEF,
    parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int unsigned ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CAP_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic [OWNER_W-1:0] i_owner_id,
    input  logic [CAP_W-1:0]   i_req_size,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic [OUT_W-1:0]   o_range_start,
    output logic [OUT_W-1:0]   o_range_end
);

    localparam int unsigned SEG_AW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned OWN_AW = $clog2(MAX_OWNERS);
    localparam int unsigned AW     = ADDR_BITS;
    localparam int unsigned WW     = AW + 1;
    localparam logic [CNT_W-1:0] SEG_MAX = CNT_W'(MAX_SEGMENTS);
    localparam logic [WW-1:0] LIMIT = WW'(1) << AW;

    t_state r_state, n_state;

    // item registers
    logic               r_cmd;
    logic [OWNER_W-1:0] r_id;
    logic [WW-1:0]      r_size;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]   r_shf, n_shf;
    logic               r_ins;
    logic [AW-1:0]      r_s, r_e;
    logic [AW-1:0]      r_ps, r_pe;
    logic               r_have_prev;
    logic [MAX_OWNERS-1:0] r_oval;

    // output register
    logic               r_ovalid;
    logic [2:0]         r_ostat;
    logic [OUT_W-1:0]   r_ors, r_ore;

    // memories
    logic              seg_we;
    logic [SEG_AW-1:0] seg_wa, seg_ra;
    logic [2*AW-1:0]   seg_wd, seg_rd;
    logic              own_we;
    logic [OWN_AW-1:0] own_wa, own_ra;
    logic [2*AW-1:0]   own_wd, own_rd;

    // seed write for reset and capacity writes shares the segment ram port
    logic              m_we;
    logic [SEG_AW-1:0] m_wa;
    logic [2*AW-1:0]   m_wd;

    ffra_ram #(.WIDTH(2*AW), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(seg_ra), .o_rdata(seg_rd)
    );

    ffra_ram #(.WIDTH(2*AW), .DEPTH(MAX_OWNERS)) u_own_ram (
        .i_clk(i_clk), .i_we(own_we), .i_waddr(own_wa), .i_wdata(own_wd),
        .i_raddr(own_ra), .o_rdata(own_rd)
    );

    logic [AW-1:0] rd_s, rd_e;
    assign rd_s = seg_rd[2*AW-1:AW];
    assign rd_e = seg_rd[AW-1:0];

    // owner table index at the table's own width
    logic [OWN_AW-1:0] id_idx;
    assign id_idx = OWN_AW'(r_id);

    logic id_ok, id_valid;
    assign id_ok    = ({{(32-OWNER_W){1'b0}}, r_id} < 32'(MAX_OWNERS));
    assign id_valid = id_ok && r_oval[id_idx];

    // segment length and fit test
    logic [WW-1:0] seg_len;
    logic          fits, exact;
    assign seg_len = {1'b0, rd_e} - {1'b0, rd_s} + WW'(1);
    assign fits    = seg_len >= r_size;
    assign exact   = seg_len == r_size;

    // free neighbour tests
    logic          jp, jn, beyond;
    assign beyond = rd_s > r_s;
    assign jp = r_have_prev && ({1'b0, r_pe} + WW'(1) == {1'b0, r_s});
    assign jn = ({1'b0, r_e} + WW'(1) == {1'b0, rd_s});

    logic idle, out_free, take_in, cfg_wr;
    assign idle     = r_state == S_IDLE;
    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = !idle;
    assign take_in  = i_valid && idle;
    assign o_cfg_ready = idle && !r_ovalid;
    assign cfg_wr   = i_cfg_valid && o_cfg_ready;

    logic [WW-1:0] cap_sat;
    assign cap_sat = ({{(WW > CAP_W ? WW-CAP_W : 0){1'b0}}, i_cfg_data} > LIMIT)
                     ? LIMIT : WW'(i_cfg_data);

    // result staging
    logic         res_stat_ok;
    logic [2:0]   res_stat;
    logic [AW-1:0] res_s, res_e;
    logic         own_set, own_clr;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take_in) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_cmd == CMD_ALLOC) begin
                    if (!id_ok || r_oval[id_idx] || r_size == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_AREAD;
                    end
                end else if (!id_valid) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_OREAD;
                end
            end
            S_AREAD: begin
                n_state = (r_pos >= r_cnt) ? S_DONE : S_ACHK;
            end
            S_ACHK: begin
                if (!fits) begin
                    n_state = S_AREAD;
                end else if (exact) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_OREAD: begin
                n_state = S_FREAD;
            end
            S_FREAD: begin
                n_state = (r_pos >= r_cnt) ? S_DONE : S_FCHK;
            end
            S_FCHK: begin
                if (!beyond) begin
                    n_state = S_FREAD;
                end else if (jp && jn) begin
                    n_state = S_SHIFT_RD;
                end else if (jp || jn || r_cnt >= SEG_MAX) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (r_ins ? (r_shf == r_pos) : (r_shf + CNT_W'(1) >= r_cnt)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                n_state = S_SHIFT_RD;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath control per state
    always_comb begin
        n_cnt   = r_cnt;
        n_pos   = r_pos;
        n_shf   = r_shf;
        seg_we  = 1'b0;
        seg_wa  = r_pos[SEG_AW-1:0];
        seg_wd  = '0;
        seg_ra  = r_pos[SEG_AW-1:0];
        own_we  = 1'b0;
        own_wa  = id_idx;
        own_wd  = {r_s, r_e};
        own_ra  = id_idx;
        res_stat = ST_OK;
        res_s   = r_s;
        res_e   = r_e;
        own_set = 1'b0;
        own_clr = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_pos = '0;
            end
            S_CHECK: begin
                if (r_cmd == CMD_ALLOC) begin
                    if (!id_ok || r_oval[id_idx]) begin
                        res_stat = ST_BUSY;
                    end else if (r_size == '0) begin
                        res_stat = ST_ZERO_SIZE;
                    end
                end else if (!id_valid) begin
                    res_stat = ST_NOT_ALLOC;
                end
            end
            S_AREAD: begin
                if (r_pos >= r_cnt) begin
                    res_stat = ST_NO_SPACE;
                end
            end
            S_ACHK: begin
                if (fits) begin
                    own_we  = 1'b1;
                    own_wd  = {rd_s, AW'({1'b0, rd_s} + r_size - WW'(1))};
                    own_set = 1'b1;
                    res_s   = rd_s;
                    res_e   = AW'({1'b0, rd_s} + r_size - WW'(1));
                    if (exact) begin
                        n_shf   = r_pos;
                    end else begin
                        seg_we  = 1'b1;
                        seg_wd  = {AW'({1'b0, rd_s} + r_size), rd_e};
                    end
                end else begin
                    n_pos   = r_pos + CNT_W'(1);
                end
            end
            S_FREAD: begin
                own_clr = 1'b1;
                if (r_pos >= r_cnt) begin
                    // past the tail: no next segment
                    if (jp) begin
                        seg_we  = 1'b1;
                        seg_wa  = SEG_AW'(r_pos - CNT_W'(1));
                        seg_wd  = {r_ps, r_e};
                    end else if (r_cnt < SEG_MAX) begin
                        seg_we  = 1'b1;
                        seg_wd  = {r_s, r_e};
                        n_cnt   = r_cnt + CNT_W'(1);
                    end
                end
            end
            S_FCHK: begin
                if (!beyond) begin
                    n_pos   = r_pos + CNT_W'(1);
                end else if (jp && jn) begin
                    seg_we  = 1'b1;
                    seg_wa  = SEG_AW'(r_pos - CNT_W'(1));
                    seg_wd  = {r_ps, rd_e};
                    n_shf   = r_pos;
                end else if (jp) begin
                    seg_we  = 1'b1;
                    seg_wa  = SEG_AW'(r_pos - CNT_W'(1));
                    seg_wd  = {r_ps, r_e};
                end else if (jn) begin
                    seg_we  = 1'b1;
                    seg_wd  = {r_s, rd_e};
                end else if (r_cnt < SEG_MAX) begin
                    // insert: shift tail up from the end
                    n_shf   = r_cnt;
                end
            end
            S_SHIFT_RD: begin
                if (r_ins) begin
                    // moving entry shf-1 to shf
                    if (r_shf == r_pos) begin
                        seg_we  = 1'b1;
                        seg_wd  = {r_s, r_e};
                        n_cnt   = r_cnt + CNT_W'(1);
                    end else begin
                        seg_ra  = SEG_AW'(r_shf - CNT_W'(1));
                    end
                end else begin
                    // moving entry shf+1 to shf
                    if (r_shf + CNT_W'(1) >= r_cnt) begin
                        n_cnt   = r_cnt - CNT_W'(1);
                    end else begin
                        seg_ra  = SEG_AW'(r_shf + CNT_W'(1));
                    end
                end
            end
            S_SHIFT_WR: begin
                seg_we = 1'b1;
                seg_wa = r_shf[SEG_AW-1:0];
                seg_wd = seg_rd;
                n_shf  = r_ins ? r_shf - CNT_W'(1) : r_shf + CNT_W'(1);
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    assign res_stat_ok = res_stat == ST_OK;

    // result capture flag, raised where the item's answer is settled
    logic go_done;
    assign go_done = (n_state == S_DONE) && (r_state != S_DONE);

    logic [2:0] r_rstat;
    logic [AW-1:0] r_rs, r_re;

    // state, list and owner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= CNT_W'(1);
            r_oval   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_oval <= '0;
                r_cnt  <= (cap_sat == '0) ? '0 : CNT_W'(1);
            end else begin
                r_cnt  <= n_cnt;
            end
            if (own_set) begin
                r_oval[id_idx] <= 1'b1;
            end
            if (own_clr && r_state == S_FREAD && r_pos == '0) begin
                r_oval[id_idx] <= 1'b0;
            end
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // after reset the single segment [0, 65535] is written by the seeding pass
    logic r_seed;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 1'b1;
        end else begin
            r_seed <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_shf <= n_shf;
        if (take_in) begin
            r_cmd  <= i_cmd;
            r_id   <= i_owner_id;
            r_size <= ({{(WW > CAP_W ? WW-CAP_W : 0){1'b0}}, i_req_size} > LIMIT)
                      ? LIMIT + WW'(1) : WW'(i_req_size);
            r_have_prev <= 1'b0;
            r_ins  <= 1'b0;
        end
        if (r_state == S_OREAD) begin
            r_s <= own_rd[2*AW-1:AW];
            r_e <= own_rd[AW-1:0];
        end
        // granted range kept for a grant that still has to drop its segment
        if (r_state == S_ACHK && fits) begin
            r_s <= res_s;
            r_e <= res_e;
        end
        if (r_state == S_FCHK && !beyond) begin
            r_ps <= rd_s;
            r_pe <= rd_e;
            r_have_prev <= 1'b1;
        end
        if (r_state == S_FCHK && beyond && !jp && !jn) begin
            r_ins <= 1'b1;
        end
        if (go_done) begin
            r_rstat <= res_stat;
            r_rs    <= res_stat_ok ? res_s : '0;
            r_re    <= res_stat_ok ? res_e : '0;
        end
        if (r_state == S_DONE && out_free) begin
            r_ostat <= r_rstat;
            r_ors   <= OUT_W'(r_rs);
            r_ore   <= OUT_W'(r_re);
        end
    end

    // a capacity write wins over the reset seed
    logic          seed_we;
    logic [AW-1:0] seed_end;
    assign seed_we  = r_seed || (cfg_wr && cap_sat != '0);
    assign seed_end = (cfg_wr && i_rst_n) ? AW'(cap_sat - WW'(1))
                                          : AW'(CAP_RESET - 33'd1);

    assign m_we = seg_we || seed_we;
    assign m_wa = seed_we ? '0 : seg_wa;
    assign m_wd = seed_we ? {{AW{1'b0}}, seed_end} : seg_wd;

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostat;
    assign o_range_start = r_ors;
    assign o_range_end   = r_ore;

    // the list never holds more segments than its depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= SEG_MAX)
        else $error("segment count overflow");

    // a result is raised only from the done state
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result without finished item");

    // no item is taken while work is in flight
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input accepted while busy");

endmodule
